// ===== hdl/spq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    typedef logic [1:0]  t_req;
    typedef logic [15:0] t_key;
    typedef logic [15:0] t_value;
    typedef logic [1:0]  t_status;

    localparam t_req REQ_PUSH = 2'd0;
    localparam t_req REQ_POP  = 2'd1;
    localparam t_req REQ_PEEK = 2'd2;

    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_EMPTY = 2'd1;
    localparam t_status STATUS_FULL  = 2'd2;

    typedef struct packed {
        t_key   key;
        t_value value;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== hdl/spq_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface spq_req_if;
    logic           valid;
    logic           ready;
    spq_pkg::t_req   req_type;
    spq_pkg::t_key   entry_priority;
    spq_pkg::t_value entry_value;

    modport source (output valid, output req_type, output entry_priority,
                    output entry_value, input ready);
    modport sink   (input valid, input req_type, input entry_priority,
                    input entry_value, output ready);
endinterface

interface spq_rsp_if;
    logic             valid;
    logic             ready;
    spq_pkg::t_value  out_value;
    spq_pkg::t_status status;

    modport source (output valid, output out_value, output status, input ready);
    modport sink   (input valid, input out_value, input status, output ready);
endinterface

`default_nettype wire

// ===== hdl/sorted_priority_queue_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Payload                                  Transfer
// i_req    in   req_type, entry_priority, entry_value    valid & ready
// o_rsp    out  out_value, status                        valid & ready
//
// One request per cycle while i_req.ready is high; each gives one registered response the cycle after.
// Push and pop update the cells in the same cycle: on pop every cell shifts from its upper
//   neighbor; on push each cell sorting after the new entry takes it or its lower neighbor's.
// i_req.ready drops only while a response waits and o_rsp.ready is low.
// Synchronous active-low reset empties the queue; no clearing pass.

module sorted_priority_queue_core #(
    parameter int DEPTH = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    spq_req_if.sink     i_req,
    spq_rsp_if.source   o_rsp
);
    import spq_pkg::*;

    t_entry           w_entry [DEPTH];
    logic [DEPTH-1:0] w_vld;
    logic [DEPTH-1:0] w_gt;
    t_entry           w_new;
    t_cell_ctrl       w_ctrl;
    logic             w_xfer;
    logic             w_full;
    logic             w_empty;

    logic    r_out_valid, n_out_valid;
    t_value  r_out_value, n_out_value;
    t_status r_status, n_status;

    assign w_new.key   = i_req.entry_priority;
    assign w_new.value = i_req.entry_value;
    assign w_full      = w_vld[DEPTH-1];
    assign w_empty     = !w_vld[0];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_xfer      = i_req.valid && i_req.ready;

    assign w_ctrl.push = w_xfer && (i_req.req_type == REQ_PUSH) && !w_full;
    assign w_ctrl.pop  = w_xfer && (i_req.req_type == REQ_POP) && !w_empty;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_entry w_prev_entry, w_next_entry;
        logic   w_prev_valid, w_prev_gt, w_next_valid;

        if (i == 0) begin : g_head
            assign w_prev_entry = w_new;
            assign w_prev_valid = 1'b0;
            assign w_prev_gt    = 1'b0;
        end else begin : g_body
            assign w_prev_entry = w_entry[i-1];
            assign w_prev_valid = w_vld[i-1];
            assign w_prev_gt    = w_gt[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign w_next_entry = w_new;
            assign w_next_valid = 1'b0;
        end else begin : g_link
            assign w_next_entry = w_entry[i+1];
            assign w_next_valid = w_vld[i+1];
        end

        spq_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctrl         (w_ctrl),
            .i_new          (w_new),
            .i_prev_entry   (w_prev_entry),
            .i_prev_valid   (w_prev_valid),
            .i_prev_greater (w_prev_gt),
            .i_next_entry   (w_next_entry),
            .i_next_valid   (w_next_valid),
            .o_entry        (w_entry[i]),
            .o_valid        (w_vld[i]),
            .o_greater      (w_gt[i])
        );
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_status    = r_status;
        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_xfer) begin
            n_out_valid = 1'b1;
            n_out_value = '0;
            n_status    = STATUS_OK;
            unique case (i_req.req_type)
                REQ_PUSH: begin
                    if (w_full) begin
                        n_status = STATUS_FULL;
                    end
                end
                REQ_POP, REQ_PEEK: begin
                    if (w_empty) begin
                        n_status = STATUS_EMPTY;
                    end else begin
                        n_out_value = w_entry[0].value;
                    end
                end
                default: begin
                    n_status = STATUS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value <= n_out_value;
        r_status    <= n_status;
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.out_value = r_out_value;
    assign o_rsp.status    = r_status;

    a_vld_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_vld >> 1) & ~w_vld) == '0)
        else $error("occupied cells not contiguous");

    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.push |=> $countones(w_vld) == $past($countones(w_vld)) + 1)
        else $error("push did not add one entry");

    a_pop_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.pop |=> $countones(w_vld) + 1 == $past($countones(w_vld)))
        else $error("pop did not remove one entry");

    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vld[1] |-> (w_entry[0].key < w_entry[1].key)
                     || ((w_entry[0].key == w_entry[1].key)
                         && (w_entry[0].value <= w_entry[1].value)))
        else $error("front entries out of order");

endmodule

`default_nettype wire

// ===== hdl/spq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire spq_pkg::t_cell_ctrl i_ctrl,
    input  wire spq_pkg::t_entry     i_new,
    input  wire spq_pkg::t_entry     i_prev_entry,
    input  wire logic                i_prev_valid,
    input  wire logic                i_prev_greater,
    input  wire spq_pkg::t_entry     i_next_entry,
    input  wire logic                i_next_valid,
    output spq_pkg::t_entry          o_entry,
    output logic                     o_valid,
    output logic                     o_greater
);
    import spq_pkg::*;

    t_entry r_entry, n_entry;
    logic   r_valid, n_valid;

    // empty slots sort after everything
    always_comb begin
        o_greater = !r_valid
                    || (r_entry.key > i_new.key)
                    || ((r_entry.key == i_new.key) && (r_entry.value > i_new.value));
    end

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        priority if (i_ctrl.pop) begin
            n_entry = i_next_entry;
            n_valid = i_next_valid;
        end else if (i_ctrl.push && o_greater) begin
            if (i_prev_greater) begin
                n_entry = i_prev_entry;
                n_valid = i_prev_valid;
            end else begin
                n_entry = i_new;
                n_valid = 1'b1;
            end
        end else begin
            // hold
            n_entry = r_entry;
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;

endmodule

`default_nettype wire
